// ===== src/ehc_pkg.sv =====
// Shared types and constants for the expiring hash cache.
`default_nettype none
package ehc_pkg;
  localparam int INDEX_BITS_DEF = 10;
  localparam int KEY_W = 32;
  localparam int SIDX_W = 10;
  localparam int TIME_W = 48;
  localparam int LIFE_W = 22;
  localparam int LT_US_W = 32;
  localparam int CMD_W = 2;
  localparam logic [LIFE_W-1:0] LIFE_RST = 22'd1000;
  localparam logic [9:0] US_PER_MS = 10'd1000;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TOUCH  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PIN    = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [SIDX_W-1:0] sidx;
    logic [TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic              full;
    logic [SIDX_W-1:0] slot;
    logic              hit;
  } res_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] expiry;
    logic              used;
    logic              pinned;
  } entry_t;
endpackage
`default_nettype wire

// ===== src/ehc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ehc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/ehc_front.sv =====
// Front end: takes requests and queues them for the table engine.
`default_nettype none
module ehc_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         clearing,
  input  wire logic         in_valid,
  output      logic         in_ready,
  input  wire ehc_pkg::req_t in_req,
  output      logic         q_valid,
  input  wire logic         q_ready,
  output      ehc_pkg::req_t q_req
);
  ehc_pkg::req_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2) && !clearing;
  assign q_valid  = (count != 2'd0);
  assign q_req    = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_req;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end
endmodule
`default_nettype wire

// ===== src/ehc_back.sv =====
// Back end: probes the table, updates entries and synonym counts.
`default_nettype none
module ehc_back #(
  parameter int INDEX_BITS = ehc_pkg::INDEX_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic [ehc_pkg::LIFE_W-1:0] cfg_wr_data,
  input  wire logic         q_valid,
  output      logic         q_ready,
  input  wire ehc_pkg::req_t q_req,
  output      logic         clearing,
  output      logic         out_valid,
  input  wire logic         out_ready,
  output      ehc_pkg::res_t out_res
);
  localparam int IW = INDEX_BITS;
  localparam int DEPTH = 1 << IW;
  localparam int EW = $bits(ehc_pkg::entry_t);
  localparam int CW = IW + 1;

  localparam logic [3:0] ST_CLR     = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_LK_SYN  = 4'd2;
  localparam logic [3:0] ST_LK_NEED = 4'd3;
  localparam logic [3:0] ST_PR_RD   = 4'd4;
  localparam logic [3:0] ST_PR_CHK  = 4'd5;
  localparam logic [3:0] ST_DEC_RD  = 4'd6;
  localparam logic [3:0] ST_DEC_WR  = 4'd7;
  localparam logic [3:0] ST_INC_RD  = 4'd8;
  localparam logic [3:0] ST_INC_WR  = 4'd9;
  localparam logic [3:0] ST_RMW_RD  = 4'd10;
  localparam logic [3:0] ST_RMW_WR  = 4'd11;

  logic [3:0]  state;
  ehc_pkg::req_t  cur;
  ehc_pkg::entry_t victim;
  logic [IW-1:0] pos;
  logic [IW-1:0] clr_cnt;
  logic [CW-1:0] cnt;
  logic [CW-1:0] seen;
  logic [CW-1:0] need;
  logic [ehc_pkg::LIFE_W-1:0] lifetime;
  logic [ehc_pkg::LT_US_W-1:0] lt_us;

  logic [IW-1:0] home;
  logic [IW-1:0] new_home;
  logic [IW-1:0] victim_home;
  logic [EW-1:0] ent_rbits;
  ehc_pkg::entry_t ent_rd;
  ehc_pkg::entry_t ent_wd;
  logic          ent_we;
  logic [IW-1:0] ent_waddr;
  logic [CW-1:0] syn_rd;
  logic [CW-1:0] syn_wd;
  logic          syn_we;
  logic [IW-1:0] syn_waddr;
  logic [IW-1:0] syn_raddr;
  logic [ehc_pkg::TIME_W:0] exp_sum;
  logic [ehc_pkg::TIME_W-1:0] exp_new;
  logic          expired;
  logic          match_home;
  logic [CW-1:0] cnt_n;
  logic [CW-1:0] seen_n;

  assign home        = cur.key[IW-1:0];
  assign new_home    = q_req.key[IW-1:0];
  assign victim_home = victim.key[IW-1:0];
  assign ent_rd      = ehc_pkg::entry_t'(ent_rbits);
  assign clearing    = (state == ST_CLR);
  assign q_ready     = (state == ST_IDLE) && !out_valid;

  assign exp_sum = {1'b0, cur.now} + (ehc_pkg::TIME_W + 1)'(lt_us);
  assign exp_new = exp_sum[ehc_pkg::TIME_W] ? '1 : exp_sum[ehc_pkg::TIME_W-1:0];
  assign expired = (ent_rd.expiry < cur.now) && !ent_rd.pinned;
  assign match_home = ent_rd.used && (ent_rd.key[IW-1:0] == home);
  assign cnt_n  = cnt + CW'(1);
  assign seen_n = seen + CW'(match_home);

  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = pos;
    ent_wd    = ent_rd;
    syn_we    = 1'b0;
    syn_waddr = home;
    syn_wd    = syn_rd + CW'(1);
    syn_raddr = (state == ST_DEC_RD) ? victim_home : home;
    case (state)
      ST_CLR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_cnt;
        ent_wd    = '0;
        syn_we    = 1'b1;
        syn_waddr = clr_cnt;
        syn_wd    = '0;
      end
      ST_DEC_WR: begin
        syn_we    = 1'b1;
        syn_waddr = victim_home;
        syn_wd    = (syn_rd == '0) ? '0 : syn_rd - CW'(1);
      end
      ST_INC_WR: begin
        syn_we        = 1'b1;
        ent_we        = 1'b1;
        ent_wd.key    = cur.key;
        ent_wd.expiry = (cur.now != '0) ? exp_new : victim.expiry;
        ent_wd.used   = 1'b1;
        ent_wd.pinned = 1'b0;
      end
      ST_RMW_WR: begin
        ent_we = 1'b1;
        if (cur.cmd == ehc_pkg::CMD_TOUCH) ent_wd.expiry = exp_new;
        else ent_wd.pinned = 1'b1;
      end
      default: ;
    endcase
  end

  ehc_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(EW'(ent_wd)),
    .raddr(pos), .rdata(ent_rbits)
  );

  ehc_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_syn_ram (
    .clk(clk), .we(syn_we), .waddr(syn_waddr), .wdata(syn_wd),
    .raddr(syn_raddr), .rdata(syn_rd)
  );

  always_ff @(posedge clk) begin
    lt_us <= ehc_pkg::LT_US_W'(lifetime * ehc_pkg::US_PER_MS);
    if (rst) begin
      state     <= ST_CLR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      lifetime  <= ehc_pkg::LIFE_RST;
    end else begin
      if (cfg_wr_en) lifetime <= cfg_wr_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + IW'(1);
          if (clr_cnt == '1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid && !out_valid) begin
            cur  <= q_req;
            cnt  <= '0;
            seen <= '0;
            case (q_req.cmd)
              ehc_pkg::CMD_LOOKUP: begin
                pos   <= new_home;
                state <= ST_LK_SYN;
              end
              ehc_pkg::CMD_INSERT: begin
                pos   <= new_home;
                state <= ST_PR_RD;
              end
              default: begin
                pos   <= IW'(q_req.sidx);
                state <= ST_RMW_RD;
              end
            endcase
          end
        end
        ST_LK_SYN: state <= ST_LK_NEED;
        ST_LK_NEED: begin
          need <= syn_rd;
          if (syn_rd == '0) begin
            out_valid <= 1'b1;
            out_res   <= '0;
            state     <= ST_IDLE;
          end else begin
            state <= ST_PR_RD;
          end
        end
        ST_PR_RD: state <= ST_PR_CHK;
        ST_PR_CHK: begin
          cnt  <= cnt_n;
          seen <= seen_n;
          if (cur.cmd == ehc_pkg::CMD_LOOKUP) begin
            if (match_home && ent_rd.key == cur.key && !expired) begin
              out_valid    <= 1'b1;
              out_res.hit  <= 1'b1;
              out_res.slot <= ehc_pkg::SIDX_W'(pos);
              out_res.full <= 1'b0;
              state        <= ST_IDLE;
            end else if (cnt_n[IW] || seen_n == need) begin
              out_valid <= 1'b1;
              out_res   <= '0;
              state     <= ST_IDLE;
            end else begin
              pos   <= pos + IW'(1);
              state <= ST_PR_RD;
            end
          end else begin
            if (!ent_rd.used || expired) begin
              victim <= ent_rd;
              state  <= ent_rd.used ? ST_DEC_RD : ST_INC_RD;
            end else if (cnt_n[IW]) begin
              out_valid    <= 1'b1;
              out_res.hit  <= 1'b0;
              out_res.slot <= '0;
              out_res.full <= 1'b1;
              state        <= ST_IDLE;
            end else begin
              pos   <= pos + IW'(1);
              state <= ST_PR_RD;
            end
          end
        end
        ST_DEC_RD: state <= ST_DEC_WR;
        ST_DEC_WR: state <= ST_INC_RD;
        ST_INC_RD: state <= ST_INC_WR;
        ST_INC_WR: begin
          out_valid    <= 1'b1;
          out_res.hit  <= 1'b1;
          out_res.slot <= ehc_pkg::SIDX_W'(pos);
          out_res.full <= 1'b0;
          state        <= ST_IDLE;
        end
        ST_RMW_RD: state <= ST_RMW_WR;
        ST_RMW_WR: begin
          out_valid    <= 1'b1;
          out_res.hit  <= 1'b0;
          out_res.slot <= ehc_pkg::SIDX_W'(pos);
          out_res.full <= 1'b0;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/expiring_hash_cache.sv =====
// Touch/pin read and rewrite the slot named by slot_index; lookup reads the home synonym count and then
// probes slots; insert probes slots and, when an expired entry is evicted, first decrements its home's count.
// Probes go through the entry RAM's single read port, one slot at a time; one request is in the engine at a time,
// two more wait in the input queue. After reset a clearing pass writes every slot with s_tready low;
// config is taken throughout.
// Top level: expiring hash cache.
`default_nettype none
module expiring_hash_cache #(
  parameter int INDEX_BITS = ehc_pkg::INDEX_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [21:0] cfg_wr_data,   // lifetime_ms
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [95:0] s_tdata,       // key[31:0], slot_index[41:32], now_us[89:42]
  input  wire logic [1:0]  s_tuser,       // cmd
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [15:0] m_tdata        // hit[0], slot[10:1], full_res[11]
);
  ehc_pkg::req_t in_req;
  ehc_pkg::req_t q_req;
  ehc_pkg::res_t res;
  logic q_valid;
  logic q_ready;
  logic clearing;

  assign in_req.cmd  = s_tuser;
  assign in_req.key  = s_tdata[31:0];
  assign in_req.sidx = s_tdata[41:32];
  assign in_req.now  = s_tdata[89:42];
  assign m_tdata     = {4'd0, res};

  ehc_front u_front (
    .clk(clk), .rst(rst), .clearing(clearing),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  ehc_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .clearing(clearing), .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );
endmodule
`default_nettype wire

// ===== src/ehc_checker.sv =====
// Port-level checks for the expiring hash cache, bound to the top level.
`default_nettype none
module ehc_port_props (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);
  // clearing pass holds off requests right after reset
  a_clear_hold: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("request accepted during clearing pass");

  a_out_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // a full table never reports a hit or a slot
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |-> !m_tdata[0] && m_tdata[10:1] == 10'd0)
    else $error("full result with hit or slot");
endmodule

bind expiring_hash_cache ehc_port_props u_ehc_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
